/* rtl/core/ttg_pkg.sv */
// ============================================================================
// ttg_pkg - triangle tangent generator shared definitions
// Widths, fixed-point constants and controller/datapath interface types.
// ============================================================================
`default_nettype none

package ttg_pkg;

    // Arithmetic widths taken from the vertex fields
    localparam int POS_WIDTH    = 32;
    localparam int TEX_WIDTH    = 16;
    localparam int TANGENT_FRAC = 14;

    // Port field widths (fixed)
    localparam int POS_FIELD_W  = 32;
    localparam int TEX_FIELD_W  = 16;
    localparam int OUT_W        = 16;
    localparam int CORNER_W     = 2;
    localparam int S_TDATA_W    = 3 * POS_FIELD_W + TEX_FIELD_W;
    localparam int M_FIELDS_W   = 3 * OUT_W + CORNER_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W      = M_TDATA_W - M_FIELDS_W;

    localparam int CORNERS      = 3;
    localparam int AXES         = 3;
    localparam logic [1:0] HELD_FULL = 2'd2;

    // Highest bit of the largest magnitude after normalization
    localparam int NORM_TOP     = 29;

    // Datapath widths
    localparam int DV_W    = TEX_WIDTH + 1;
    localparam int E_W     = POS_WIDTH + 1;
    localparam int T_W     = DV_W + E_W + 1;
    localparam int MAG_W   = (T_W > NORM_TOP + 2) ? T_W : NORM_TOP + 2;
    localparam int MUL_A_W = (E_W > NORM_TOP + 2) ? E_W : NORM_TOP + 2;
    localparam int MUL_B_W = (DV_W > NORM_TOP + 2) ? DV_W : NORM_TOP + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 2 * (NORM_TOP + 1) + 2;
    localparam int N_W     = SUM_W / 2;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int QW      = TANGENT_FRAC + 1;
    localparam int NUM_W   = NORM_TOP + 2 + TANGENT_FRAC;
    localparam int DIV_STEPS = QW;

    localparam int CNT_MAX0 = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
    localparam int CNT_MAX  = (CNT_MAX0 > 2 * AXES + 1) ? CNT_MAX0 : 2 * AXES + 1;
    localparam int CNT_W    = $clog2(CNT_MAX);

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MUL_DV2_E1 = 2'd0,
        MUL_DV1_E2 = 2'd1,
        MUL_SQ     = 2'd2
    } mul_op_t;

    typedef struct packed {
        logic       hold_wr;
        logic       hold_idx;
        logic       tri_ld;
        logic       mul_en;
        mul_op_t    mul_op;
        logic [1:0] idx;
        logic       abs_en;
        logic       max_en;
        logic       norm_en;
        logic       sqrt_init;
        logic       sqrt_en;
        logic       div_init;
        logic       div_en;
        logic       div_store;
    } ttg_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic degenerate;
    } ttg_status_t;

endpackage

`default_nettype wire

/* rtl/core/ttg_datapath.sv */
// ============================================================================
// ttg_datapath - tangent arithmetic
// Vertex store, edge products on one shared multiplier, normalization,
// digit-serial square root and restoring division.
// ============================================================================
`default_nettype none

module ttg_datapath
    import ttg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ttg_cmd_t             cmd,
    input  wire logic [POS_WIDTH-1:0] pos_x,
    input  wire logic [POS_WIDTH-1:0] pos_y,
    input  wire logic [POS_WIDTH-1:0] pos_z,
    input  wire logic [TEX_WIDTH-1:0] tex_v,
    output ttg_status_t               status,
    output logic [OUT_W-1:0]          tangent_x,
    output logic [OUT_W-1:0]          tangent_y,
    output logic [OUT_W-1:0]          tangent_z,
    output logic                      degenerate
);

    localparam int SAT_W = (QW + 1 > OUT_W + 1) ? QW + 1 : OUT_W + 1;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

    logic [POS_WIDTH-1:0]        held_pos_reg [2][AXES];
    logic [TEX_WIDTH-1:0]        held_tex_reg [2];
    logic [POS_WIDTH-1:0]        in_pos [AXES];

    logic signed [E_W-1:0]       e1_reg [AXES];
    logic signed [E_W-1:0]       e2_reg [AXES];
    logic signed [DV_W-1:0]      dv1_reg;
    logic signed [DV_W-1:0]      dv2_reg;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        acc_vld_reg;
    mul_op_t                     acc_op_reg;
    logic [1:0]                  acc_idx_reg;

    logic signed [T_W-1:0]       t_reg [AXES];
    logic [T_W-1:0]              t_abs [AXES];
    logic [MAG_W-1:0]            mag_reg [AXES];
    logic [AXES-1:0]             neg_reg;
    logic [MAG_W-1:0]            m_reg;
    logic [MAG_W-1:0]            mag_max;
    logic                        deg_reg;
    logic                        shr8;
    logic                        shr1;
    logic                        shl8;

    logic [SUM_W-1:0]            x_reg;
    logic [SUM_W-1:0]            res_reg;
    logic [SUM_W-1:0]            bit_reg;
    logic [SUM_W-1:0]            sq_tmp;
    logic [SUM_W:0]              sq_diff;

    logic [N_W-1:0]              root;
    logic [NUM_W-1:0]            num;
    logic [N_W-1:0]              r_reg;
    logic [N_W:0]                r2;
    logic [N_W+1:0]              rd;
    logic [QW-1:0]               q_reg;
    logic [QW-1:0]               nl_reg;

    logic signed [SAT_W-1:0]     q_s;
    logic signed [SAT_W-1:0]     q_sgn;
    logic signed [SAT_W-1:0]     q_sat;
    logic [OUT_W-1:0]            tan_reg [AXES];

    assign in_pos[0] = pos_x;
    assign in_pos[1] = pos_y;
    assign in_pos[2] = pos_z;

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            MUL_DV2_E1:
            begin
                mul_a = MUL_A_W'(e1_reg[cmd.idx]);
                mul_b = MUL_B_W'(dv2_reg);
            end
            MUL_DV1_E2:
            begin
                mul_a = MUL_A_W'(e2_reg[cmd.idx]);
                mul_b = MUL_B_W'(dv1_reg);
            end
            MUL_SQ:
            begin
                mul_a = MUL_A_W'(mag_reg[cmd.idx][NORM_TOP:0]);
                mul_b = MUL_B_W'(mag_reg[cmd.idx][NORM_TOP:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < AXES; c++)
        begin
            t_abs[c] = t_reg[c][T_W-1] ? $unsigned(-t_reg[c]) : $unsigned(t_reg[c]);
        end
        mag_max = mag_reg[0];
        if (mag_reg[1] > mag_max)
        begin
            mag_max = mag_reg[1];
        end
        if (mag_reg[2] > mag_max)
        begin
            mag_max = mag_reg[2];
        end
    end

    // Normalize step: coarse shift by 8, fine shift by 1
    assign shr8 = (m_reg >> (NORM_TOP + 9)) != '0;
    assign shr1 = (m_reg >> (NORM_TOP + 1)) != '0;
    assign shl8 = (m_reg >> (NORM_TOP - 8)) == '0;

    // Root digit recurrence
    assign sq_tmp  = res_reg + bit_reg;
    assign sq_diff = {1'b0, x_reg} - {1'b0, sq_tmp};

    // Restoring division: quotient bounded by 2^TANGENT_FRAC
    assign root = res_reg[N_W-1:0];
    assign num  = (NUM_W'(mag_reg[cmd.idx][NORM_TOP:0]) << TANGENT_FRAC)
                + NUM_W'(root >> 1);
    assign r2   = {r_reg, nl_reg[QW-1]};
    assign rd   = {1'b0, r2} - {2'b0, root};

    always_comb
    begin
        q_s   = $signed(SAT_W'(q_reg));
        q_sgn = neg_reg[cmd.idx] ? -q_s : q_s;
        if (q_sgn > SAT_HI)
        begin
            q_sat = SAT_HI;
        end
        else if (q_sgn < SAT_LO)
        begin
            q_sat = SAT_LO;
        end
        else
        begin
            q_sat = q_sgn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= 1'b0;
        end
        else
        begin
            acc_vld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_wr)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                held_pos_reg[cmd.hold_idx][c] <= in_pos[c];
            end
            held_tex_reg[cmd.hold_idx] <= tex_v;
        end

        if (cmd.tri_ld)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                e1_reg[c] <= E_W'($signed(held_pos_reg[1][c]))
                           - E_W'($signed(held_pos_reg[0][c]));
                e2_reg[c] <= E_W'($signed(in_pos[c]))
                           - E_W'($signed(held_pos_reg[0][c]));
            end
            dv1_reg <= DV_W'($signed(held_tex_reg[1])) - DV_W'($signed(held_tex_reg[0]));
            dv2_reg <= DV_W'($signed(tex_v)) - DV_W'($signed(held_tex_reg[0]));
        end

        if (cmd.mul_en)
        begin
            prod_reg    <= mul_a * mul_b;
            acc_op_reg  <= cmd.mul_op;
            acc_idx_reg <= cmd.idx;
        end

        // Accumulate the product registered in the previous cycle
        if (acc_vld_reg)
        begin
            case (acc_op_reg)
                MUL_DV2_E1: t_reg[acc_idx_reg] <= T_W'(prod_reg);
                MUL_DV1_E2: t_reg[acc_idx_reg] <= t_reg[acc_idx_reg] - T_W'(prod_reg);
                MUL_SQ:
                begin
                    if (acc_idx_reg == 2'd0)
                    begin
                        x_reg <= SUM_W'(prod_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg + SUM_W'(prod_reg);
                    end
                end
                default: ;
            endcase
        end

        if (cmd.abs_en)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                mag_reg[c] <= MAG_W'(t_abs[c]);
                neg_reg[c] <= t_reg[c][T_W-1];
            end
        end

        if (cmd.max_en)
        begin
            m_reg   <= mag_max;
            deg_reg <= (mag_max == '0);
            if (mag_max == '0)
            begin
                for (int c = 0; c < AXES; c++)
                begin
                    tan_reg[c] <= '0;
                end
            end
        end

        if (cmd.norm_en)
        begin
            if (shr8)
            begin
                m_reg <= m_reg >> 8;
                for (int c = 0; c < AXES; c++) mag_reg[c] <= mag_reg[c] >> 8;
            end
            else if (shr1)
            begin
                m_reg <= m_reg >> 1;
                for (int c = 0; c < AXES; c++) mag_reg[c] <= mag_reg[c] >> 1;
            end
            else if (shl8)
            begin
                m_reg <= m_reg << 8;
                for (int c = 0; c < AXES; c++) mag_reg[c] <= mag_reg[c] << 8;
            end
            else
            begin
                m_reg <= m_reg << 1;
                for (int c = 0; c < AXES; c++) mag_reg[c] <= mag_reg[c] << 1;
            end
        end

        if (cmd.sqrt_init)
        begin
            res_reg <= '0;
            bit_reg <= SUM_W'(1) << (SUM_W - 2);
        end

        if (cmd.sqrt_en)
        begin
            if (!sq_diff[SUM_W])
            begin
                x_reg   <= sq_diff[SUM_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.div_init)
        begin
            r_reg  <= N_W'(num[NUM_W-1:QW]);
            nl_reg <= num[QW-1:0];
            q_reg  <= '0;
        end

        if (cmd.div_en)
        begin
            if (!rd[N_W+1])
            begin
                r_reg <= rd[N_W-1:0];
                q_reg <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r2[N_W-1:0];
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
            nl_reg <= nl_reg << 1;
        end

        if (cmd.div_store)
        begin
            tan_reg[cmd.idx] <= q_sat[OUT_W-1:0];
        end
    end

    assign status.norm_done  = (m_reg >> NORM_TOP) == MAG_W'(1);
    assign status.degenerate = deg_reg;

    assign tangent_x  = tan_reg[0];
    assign tangent_y  = tan_reg[1];
    assign tangent_z  = tan_reg[2];
    assign degenerate = deg_reg;

endmodule

`default_nettype wire

/* rtl/core/ttg_ctrl.sv */
// ============================================================================
// ttg_ctrl - triangle tangent sequencer
// Vertex counting, handshake control and step sequencing of the datapath.
// ============================================================================
`default_nettype none

module ttg_ctrl
    import ttg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_restart,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [1:0]       corner,
    output ttg_cmd_t         cmd,
    input  wire ttg_status_t status
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_MUL       = 11'b000_0000_0010,
        S_ABS       = 11'b000_0000_0100,
        S_MAX       = 11'b000_0000_1000,
        S_NORM      = 11'b000_0001_0000,
        S_SQ        = 11'b000_0010_0000,
        S_SQRT      = 11'b000_0100_0000,
        S_DIV_INIT  = 11'b000_1000_0000,
        S_DIV_STEP  = 11'b001_0000_0000,
        S_DIV_STORE = 11'b010_0000_0000,
        S_EMIT      = 11'b100_0000_0000
    } state_t;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(2 * AXES);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(AXES);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [1:0]       IDX_LAST  = 2'(AXES - 1);
    localparam logic [1:0]       CRN_LAST  = 2'(CORNERS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       idx_reg, idx_next;
    logic [1:0]       count_reg, count_next;
    logic [1:0]       corner_reg, corner_next;
    logic [1:0]       eff_count;
    logic             in_accept;

    // With two held, any vertex waits for idle; others are stored any time
    assign s_tready  = (state_reg == S_IDLE) || (count_reg != HELD_FULL);
    assign in_accept = s_tvalid && s_tready;
    assign eff_count = s_restart ? 2'd0 : count_reg;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        corner_next = corner_reg;

        if (in_accept)
        begin
            if (eff_count == HELD_FULL)
            begin
                cmd.tri_ld = 1'b1;
                count_next = 2'd0;
            end
            else
            begin
                cmd.hold_wr  = 1'b1;
                cmd.hold_idx = eff_count[0];
                count_next   = eff_count + 2'd1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && eff_count == HELD_FULL)
                begin
                    state_next = S_MUL;
                    cnt_next   = '0;
                end
            end
            S_MUL:
            begin
                cmd.mul_op = cnt_reg[0] ? MUL_DV1_E2 : MUL_DV2_E1;
                cmd.idx    = cnt_reg[2:1];
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_ABS;
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            S_ABS:
            begin
                cmd.abs_en = 1'b1;
                state_next = S_MAX;
            end
            S_MAX:
            begin
                cmd.max_en = 1'b1;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (status.degenerate)
                begin
                    state_next  = S_EMIT;
                    corner_next = 2'd0;
                end
                else if (status.norm_done)
                begin
                    state_next = S_SQ;
                    cnt_next   = '0;
                end
                else
                begin
                    cmd.norm_en = 1'b1;
                end
            end
            S_SQ:
            begin
                cmd.mul_op = MUL_SQ;
                cmd.idx    = cnt_reg[1:0];
                if (cnt_reg == SQ_LAST)
                begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SQRT;
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_en = 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_DIV_INIT;
                    idx_next   = 2'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cmd.idx      = idx_reg;
                cnt_next     = '0;
                state_next   = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.div_en = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DIV_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                cmd.idx       = idx_reg;
                if (idx_reg == IDX_LAST)
                begin
                    state_next  = S_EMIT;
                    corner_next = 2'd0;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end
            end
            S_EMIT:
            begin
                if (m_tready)
                begin
                    if (corner_reg == CRN_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            count_reg  <= '0;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            corner_reg <= corner_next;
        end
    end

    assign m_tvalid = (state_reg == S_EMIT);
    assign corner   = corner_reg;

endmodule

`default_nettype wire

/* rtl/core/triangle_tangent_generator.sv */
// ============================================================================
// triangle_tangent_generator - per-triangle unit tangent from a vertex stream
// Vertices of the next triangle: the first two are taken while the current
//   one is worked on; its third vertex waits until the sequencer is idle.
// The arithmetic runs a 31-step square root and three 15-step divisions,
//   both skipped when the triangle is degenerate.
// Reset: controller and vertex count cleared; held vertices not reset.
// ============================================================================
`default_nettype none

module triangle_tangent_generator
    import ttg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Vertex stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], tex_v[111:96]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // tuser: restart[0]
    input  wire logic [0:0]           s_tuser,

    // Tangent stream, three beats per triangle
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // tdata: tangent_x[15:0], tangent_y[31:16], tangent_z[47:32],
    //        corner[49:48], zero pad[55:50]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // tuser: degenerate[0]
    output logic [0:0]                m_tuser,
    // tlast: third beat of the triangle
    output logic                      m_tlast
);

    ttg_cmd_t         cmd;
    ttg_status_t      status;
    logic [1:0]       corner;
    logic [OUT_W-1:0] tangent_x;
    logic [OUT_W-1:0] tangent_y;
    logic [OUT_W-1:0] tangent_z;
    logic             degenerate;

    // Sequencer: counts held vertices, steps the arithmetic, drives both
    // handshakes. Leading vertices of the next triangle are taken while the
    // current one is still being worked on.
    ttg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_restart (s_tuser[0]),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .corner    (corner),
        .cmd       (cmd),
        .status    (status)
    );

    // Arithmetic: low POS_WIDTH / TEX_WIDTH bits of each field are used
    ttg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pos_x      (s_tdata[0 +: POS_WIDTH]),
        .pos_y      (s_tdata[POS_FIELD_W +: POS_WIDTH]),
        .pos_z      (s_tdata[2 * POS_FIELD_W +: POS_WIDTH]),
        .tex_v      (s_tdata[3 * POS_FIELD_W +: TEX_WIDTH]),
        .status     (status),
        .tangent_x  (tangent_x),
        .tangent_y  (tangent_y),
        .tangent_z  (tangent_z),
        .degenerate (degenerate)
    );

    // Result beat: tangent registers hold steady for all three corners
    assign m_tdata    = {{M_PAD_W{1'b0}}, corner, tangent_z, tangent_y, tangent_x};
    assign m_tuser[0] = degenerate;
    assign m_tlast    = (corner == 2'(CORNERS - 1));

endmodule

`default_nettype wire

/* tb/sv/tangent_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// tangent_checker - scoreboard for the triangle tangent generator
// Watches both streams, rebuilds each triangle's unit tangent from the
// accepted vertices and compares every tangent beat with the oldest
// outstanding prediction.
// ============================================================================

module tangent_checker
    import ttg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]           s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic [0:0]           m_tuser,
    input  wire logic                 m_tlast,
    output int                        errors,
    output int                        pending
);

    typedef struct packed {
        logic signed [OUT_W-1:0] tan_x;
        logic signed [OUT_W-1:0] tan_y;
        logic signed [OUT_W-1:0] tan_z;
        logic                    degenerate;
    } tangent_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] tan_x;
        logic signed [OUT_W-1:0] tan_y;
        logic signed [OUT_W-1:0] tan_z;
        logic [CORNER_W-1:0]     corner;
        logic                    degenerate;
        logic                    last;
    } tangent_beat_t;

    // first two vertices of the triangle in progress
    longint        anchor_pos [2][3];
    longint        anchor_v [2];
    int            verts_held;

    tangent_beat_t expected_beats [$];
    int            fail_count = 0;
    int            beats_due = 0;

    tangent_t      tan_now;
    tangent_beat_t beat_want;
    tangent_beat_t beat_got;
    longint        vtx [3];
    longint        vtx_v;

    assign errors  = fail_count;
    assign pending = beats_due;

    // digit-by-digit integer square root, floor
    function automatic bit [63:0] int_sqrt(input bit [63:0] x);
        bit [63:0] root;
        bit [63:0] rem;
        bit [63:0] trial;
        int        i;
        root = '0;
        rem  = '0;
        for (i = 31; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((x >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            root  = root << 1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(input longint val);
        if (val > 32767)
            return 16'sh7FFF;
        if (val < -32768)
            return 16'sh8000;
        return val[OUT_W-1:0];
    endfunction

    // t = dv2*e1 - dv1*e2, scaled so the biggest magnitude tops out at
    // NORM_TOP, then divided by the rounded-down length with rounding
    function automatic tangent_t triangle_tangent(input longint px, input longint py,
                                                  input longint pz, input longint pv);
        longint    cur [3];
        longint    t [3];
        bit [63:0] mag [3];
        bit [63:0] peak;
        bit [63:0] sum;
        bit [63:0] len;
        bit [63:0] q;
        longint    dv1;
        longint    dv2;
        longint    comp [3];
        int        top;
        int        c;
        tangent_t  res;
        cur[0] = px;
        cur[1] = py;
        cur[2] = pz;
        dv1  = anchor_v[1] - anchor_v[0];
        dv2  = pv - anchor_v[0];
        peak = '0;
        for (c = 0; c < AXES; c++)
        begin
            t[c]   = dv2 * (anchor_pos[1][c] - anchor_pos[0][c])
                   - dv1 * (cur[c] - anchor_pos[0][c]);
            mag[c] = (t[c] < 0) ? 64'(-t[c]) : 64'(t[c]);
            if (mag[c] > peak)
                peak = mag[c];
        end
        res.degenerate = (peak == 0);
        if (peak == 0)
        begin
            comp[0] = 0;
            comp[1] = 0;
            comp[2] = 0;
        end
        else
        begin
            top = 0;
            for (c = 0; c < 64; c++)
                if (peak[c])
                    top = c;
            sum = '0;
            for (c = 0; c < AXES; c++)
            begin
                if (top > NORM_TOP)
                    mag[c] = mag[c] >> (top - NORM_TOP);
                else
                    mag[c] = mag[c] << (NORM_TOP - top);
                sum = sum + mag[c] * mag[c];
            end
            len = int_sqrt(sum);
            for (c = 0; c < AXES; c++)
            begin
                q       = ((mag[c] << TANGENT_FRAC) + (len >> 1)) / len;
                comp[c] = (t[c] < 0) ? -longint'(q) : longint'(q);
            end
        end
        res.tan_x = clamp_out(comp[0]);
        res.tan_y = clamp_out(comp[1]);
        res.tan_z = clamp_out(comp[2]);
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verts_held = 0;
            expected_beats.delete();
            beats_due = 0;
        end
        else
        begin
            // tangent side first; a beat never depends on this edge's vertex
            if (m_tvalid && m_tready)
            begin
                beat_got.tan_x      = m_tdata[0 +: OUT_W];
                beat_got.tan_y      = m_tdata[OUT_W +: OUT_W];
                beat_got.tan_z      = m_tdata[2 * OUT_W +: OUT_W];
                beat_got.corner     = m_tdata[3 * OUT_W +: CORNER_W];
                beat_got.degenerate = m_tuser[0];
                beat_got.last       = m_tlast;
                if (expected_beats.size() == 0)
                begin
                    $error("tangent beat with nothing outstanding: x=%0d y=%0d z=%0d corner=%0d",
                           $signed(beat_got.tan_x), $signed(beat_got.tan_y),
                           $signed(beat_got.tan_z), beat_got.corner);
                    fail_count++;
                end
                else
                begin
                    beat_want = expected_beats.pop_front();
                    check_field("tangent_x", $signed(beat_want.tan_x), $signed(beat_got.tan_x));
                    check_field("tangent_y", $signed(beat_want.tan_y), $signed(beat_got.tan_y));
                    check_field("tangent_z", $signed(beat_want.tan_z), $signed(beat_got.tan_z));
                    check_field("corner", beat_want.corner, beat_got.corner);
                    check_field("degenerate", beat_want.degenerate, beat_got.degenerate);
                    check_field("last", beat_want.last, beat_got.last);
                end
            end

            if (s_tvalid && s_tready)
            begin
                vtx[0] = longint'($signed(s_tdata[0 +: POS_WIDTH]));
                vtx[1] = longint'($signed(s_tdata[POS_FIELD_W +: POS_WIDTH]));
                vtx[2] = longint'($signed(s_tdata[2 * POS_FIELD_W +: POS_WIDTH]));
                vtx_v  = longint'($signed(s_tdata[3 * POS_FIELD_W +: TEX_WIDTH]));
                // restart drops any partial triangle
                if (s_tuser[0])
                    verts_held = 0;
                if (verts_held < HELD_FULL)
                begin
                    anchor_pos[verts_held][0] = vtx[0];
                    anchor_pos[verts_held][1] = vtx[1];
                    anchor_pos[verts_held][2] = vtx[2];
                    anchor_v[verts_held]      = vtx_v;
                    verts_held++;
                end
                else
                begin
                    verts_held = 0;
                    tan_now = triangle_tangent(vtx[0], vtx[1], vtx[2], vtx_v);
                    for (int k = 0; k < CORNERS; k++)
                    begin
                        beat_want.tan_x      = tan_now.tan_x;
                        beat_want.tan_y      = tan_now.tan_y;
                        beat_want.tan_z      = tan_now.tan_z;
                        beat_want.corner     = k[CORNER_W-1:0];
                        beat_want.degenerate = tan_now.degenerate;
                        beat_want.last       = (k == CORNERS - 1);
                        expected_beats.insert(expected_beats.size(), beat_want);
                    end
                end
            end
            beats_due = expected_beats.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top - regression bench for triangle_tangent_generator
// Drives vertex beats (directed corner cases, then random triangles with
// noise and restarts) under random source and sink stalls, including one
// long sink hold-off; the checker scores every tangent beat.
// ============================================================================

module tb_top;
    import ttg_pkg::*;

    localparam int SQUEEZE_CYCLES = 400;   // long sink hold-off, fills the block
    localparam int IDLE_LIMIT     = 4000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES    = 150;   // above the worst triangle latency
    localparam int TARGET_ITEMS   = 160;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire [M_TDATA_W-1:0]  m_tdata;
    wire [0:0]            m_tuser;
    wire                  m_tlast;

    int failures;
    int beats_due;
    int vertices_sent = 0;
    int idle_cycles = 0;
    int tri_idx;
    bit steady = 1'b0;        // no idling on either side while set
    bit squeeze_req = 1'b0;
    bit squeeze_done = 1'b0;

    always #10 clk = ~clk;

    triangle_tangent_generator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tangent_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (failures),
        .pending  (beats_due)
    );

    // Source gap after a beat: mostly none, some short, a few long.
    // While the sink is squeezed the source keeps offering back to back.
    function automatic int source_gap();
        int r;
        if (steady || (squeeze_req && !squeeze_done))
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Signed coordinate with only the low 'bits' bits significant
    function automatic logic [31:0] rand_coord(input int bits);
        logic [31:0] raw;
        raw = $urandom;
        return $signed(raw) >>> (32 - bits);
    endfunction

    // One vertex beat; inputs move on the falling edge only
    task automatic send_vertex(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz, input logic [15:0] tv,
                               input bit restart);
        int gap;
        @(negedge clk);
        s_tdata  = {tv, pz, py, px};
        s_tuser  = restart;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        vertices_sent++;
        gap = source_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Mostly well-formed triangles with random content. Flavors:
    //   small coordinates (short shifts or left shifts in normalization),
    //   full-range coordinates, equal texture v (zero tangent), one vertex
    //   repeated three times, and a restart part way through the triangle.
    task automatic random_triangle();
        int          flavor;
        int          bits;
        int          cut;
        logic [31:0] px, py, pz;
        logic [15:0] tv;
        bit          restart;
        flavor = $urandom_range(0, 9);
        bits   = (flavor < 5) ? $urandom_range(4, 24) : 32;
        cut    = (flavor == 9) ? $urandom_range(1, 2) : CORNERS;
        tv     = 16'($urandom_range(0, 16'hFFFF));
        px     = rand_coord(bits);
        py     = rand_coord(bits);
        pz     = rand_coord(bits);
        for (int k = 0; k < CORNERS; k++)
        begin
            if (flavor != 8 && k > 0)
            begin
                px = rand_coord(bits);
                py = rand_coord(bits);
                pz = rand_coord(bits);
            end
            if (flavor != 7 && flavor != 8 && k > 0)
                tv = 16'($urandom_range(0, 16'hFFFF));
            // a restart on a first vertex is harmless when already aligned
            restart = (k == 0) ? ($urandom_range(0, 4) == 0) : (k == cut);
            send_vertex(px, py, pz, tv, restart);
        end
    endtask

    // Sink: random ready with short and long stalls, one long hold-off
    initial
    begin : sink
        int hold;
        int r;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                m_tready = 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
                squeeze_done = 1'b1;
            end
            if (steady)
                m_tready = 1'b1;
            else if (hold > 0)
            begin
                m_tready = 1'b0;
                hold--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    m_tready = 1'b1;
                else
                begin
                    m_tready = 1'b0;
                    hold = (r < 93) ? $urandom_range(0, 2) : $urandom_range(15, 60);
                end
            end
        end
    end

    // Watchdog: too long without a beat on either side means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("triangle_tangent_generator regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // unit +x: dv1 = 0, dv2 = 1.0, e1 along x
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0000, 1'b1);
        send_vertex(32'h0001_0000, 32'h0, 32'h0, 16'h0000, 1'b0);
        send_vertex(32'h0, 32'h0001_0000, 32'h0, 16'h1000, 1'b0);
        // unit -z: negative dv2
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0000, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h0001_0000, 16'h0000, 1'b0);
        send_vertex(32'h0, 32'h0001_0000, 32'h0, 16'hF000, 1'b0);
        // unit +y
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0000, 1'b0);
        send_vertex(32'h0, 32'h0001_0000, 32'h0, 16'h0000, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h0001_0000, 16'h1000, 1'b0);
        // field extremes: widest edges and v deltas, big right shift
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'h8000, 1'b0);
        // zero tangent: all three corners the same vertex
        send_vertex(32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 16'h1234, 1'b0);
        send_vertex(32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 16'h1234, 1'b0);
        send_vertex(32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 16'h1234, 1'b0);
        // tiny tangent: left shift all the way up
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0000, 1'b0);
        send_vertex(32'h1, 32'h0, 32'h0, 16'h0000, 1'b0);
        send_vertex(32'h0, 32'h1, 32'h0, 16'h0001, 1'b0);
        // restart on the third vertex drops the two held ones
        send_vertex(32'h0002_0000, 32'h0, 32'h0, 16'h0800, 1'b0);
        send_vertex(32'h0, 32'h0002_0000, 32'h0, 16'h0400, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0000, 1'b1);
        send_vertex(32'h0, 32'h0, 32'h0003_0000, 16'h7FFF, 1'b0);
        send_vertex(32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 16'h8000, 1'b0);

        // random part; the sink squeeze starts right away
        squeeze_req = 1'b1;
        tri_idx = 0;
        while (vertices_sent < TARGET_ITEMS)
        begin
            steady = ((tri_idx % 16) >= 12);
            random_triangle();
            tri_idx++;
        end
        steady = 1'b0;
        @(negedge clk);
        s_tvalid = 1'b0;

        while (beats_due != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("triangle_tangent_generator regression: pass");
        else
            $display("triangle_tangent_generator regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ttg_pkg.sv
rtl/core/ttg_datapath.sv
rtl/core/ttg_ctrl.sv
rtl/core/triangle_tangent_generator.sv
tb/sv/tangent_checker.sv
tb/sv/tb_top.sv
